[hdl/sles_pkg.sv]
// shared types and constants for the status led effect sequencer
// holds the flow color table, mode and register codes and the controller/datapath structs
// no dependencies
`default_nettype none

package sles_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FLOW   = 2'd1,
      MODE_ERROR  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_EFFECT_MODE  = 1'b0,
      CSR_ERROR_BLINKS = 1'b1
   } csr_index_type;

   localparam int COLOR_COUNT = 7;
   localparam logic [2:0] SEG_LAST = 3'd5;

   // argb; neighboring entries differ by full scale or not at all in every channel
   localparam logic [31:0] FLOW_COLORS [COLOR_COUNT] = '{
      32'h0F0000FF, 32'h0F00FF00, 32'h0FFF0000,
      32'h0F0000FF, 32'h0F00FF00, 32'h0FFF0000,
      32'h0F0000FF
   };

   localparam logic [7:0] DIM_ALPHA = 8'h0F;
   localparam logic [7:0] DIM_RED   = 8'hFF;
   localparam logic [7:0] PAUSE_RESET = 8'd100;

   localparam logic signed [36:0] LEVEL_MAX = 37'sd33554431;
   localparam logic signed [36:0] LEVEL_MIN = -37'sd33554432;

   typedef struct packed {
      logic       accept;
      logic       mul;
      logic       acc;
      logic       scale;
      logic       out_load;
      logic [1:0] ch;
   } dp_cmd_type;

   typedef struct packed {
      logic flow_run;
      logic err_emit;
      logic out_free;
   } dp_status_type;

   // byte k of a table color, alpha first
   function automatic logic [7:0] color_part(input logic [2:0] idx, input logic [1:0] k);
      logic [31:0] c;
      c = (idx <= 3'd6) ? FLOW_COLORS[idx] : 32'h0;
      case (k)
         2'd0:    color_part = c[31:24];
         2'd1:    color_part = c[23:16];
         2'd2:    color_part = c[15:8];
         default: color_part = c[7:0];
      endcase
   endfunction

endpackage

`default_nettype wire

[hdl/sles_ctrl.sv]
// controller state machine for the status led effect sequencer
// sequences one shared multiplier over the four channels; uses sles_pkg
`default_nettype none

module sles_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sles_pkg::dp_status_type status,
   output sles_pkg::dp_cmd_type        cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_ACC   = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in = 2'd0;
               if (status.flow_run) begin
                  state_in = ST_MUL;
               end else if (status.err_emit) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (ch_ff == 2'd3) begin
               state_in = ST_SCALE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_SCALE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.mul      = (state_ff == ST_MUL);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.out_load = (state_ff == ST_OUT) && status.out_free;
      cmd.ch       = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

`default_nettype wire

[hdl/sles_dp.sv]
// datapath for the status led effect sequencer
// config registers, fade accumulators, blink counters and the result register; uses sles_pkg
`default_nettype none

module sles_dp #(
   parameter int SEGMENT_MS  = 500,
   parameter int PAUSE_TICKS = 200,
   parameter int BLINK_TICKS = 100
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sles_pkg::dp_cmd_type    cmd,
   output sles_pkg::dp_status_type      status,
   input  wire logic [9:0]              req_elapsed_ms,
   input  wire logic                    csr_write,
   input  wire logic                    csr_index,
   input  wire logic [7:0]              csr_wdata,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue
);

   localparam logic [15:0] SEG_LIMIT  = 16'(SEGMENT_MS);
   localparam logic [7:0]  PAUSE_INIT = 8'(PAUSE_TICKS);
   localparam logic [6:0]  BLINK_FULL = 7'(BLINK_TICKS);
   localparam logic [6:0]  BLINK_HALF = 7'(BLINK_TICKS / 2);
   // per-ms step of a full-scale fade, truncated toward zero
   localparam logic signed [25:0] STEP_MAG = 26'((255 * 65536) / SEGMENT_MS);

   localparam logic [7:0] DIM_ALPHA = sles_pkg::DIM_ALPHA;
   localparam logic [7:0] DIM_RED   = sles_pkg::DIM_RED;
   localparam logic [15:0] DIM_PROD = 16'(DIM_ALPHA) * 16'(DIM_RED);

   sles_pkg::mode_type      mode_ff;
   logic [7:0]              blinks_cfg_ff;
   logic [2:0]              seg_ff;
   logic [15:0]             seg_time_ff;
   logic signed [25:0]      level_ff [4];
   logic signed [25:0]      step_ff [4];
   logic [7:0]              blinks_left_ff;
   logic [7:0]              pause_left_ff;
   logic [6:0]              phase_ff;
   logic [9:0]              d_ff;
   logic signed [36:0]      prod_ff;
   logic [15:0]             prod_rgb_ff [3];
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic [2:0]              seg_next;
   logic [16:0]             time_sum;
   logic signed [36:0]      level_sum;
   logic signed [25:0]      level_sat;
   logic [6:0]              phase_inc;
   logic                    err_restart, err_pause;
   logic                    blink_dark, blink_lit;
   logic [7:0]              alpha_ch;

   function automatic logic signed [25:0] seg_level(input logic [2:0] s, input logic [1:0] k);
      seg_level = $signed({2'b00, sles_pkg::color_part(s, k), 16'h0000});
   endfunction

   function automatic logic signed [25:0] seg_step(input logic [2:0] s, input logic [1:0] k);
      logic [7:0] cur, nxt;
      cur = sles_pkg::color_part(s, k);
      nxt = sles_pkg::color_part(s + 3'd1, k);
      if (nxt > cur) begin
         seg_step = STEP_MAG;
      end else if (nxt < cur) begin
         seg_step = -STEP_MAG;
      end else begin
         seg_step = 26'sd0;
      end
   endfunction

   // integer part clamped to 0..255
   function automatic logic [7:0] to_channel(input logic signed [25:0] lv);
      if (lv[25]) begin
         to_channel = 8'd0;
      end else if (lv[24]) begin
         to_channel = 8'hFF;
      end else begin
         to_channel = lv[23:16];
      end
   endfunction

   // exact x / 255 for any product of two bytes
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      div255 = s[15:8];
   endfunction

   assign seg_next  = (seg_ff >= sles_pkg::SEG_LAST) ? 3'd0 : seg_ff + 3'd1;
   assign time_sum  = 17'(seg_time_ff) + 17'(req_elapsed_ms);
   assign level_sum = 37'(level_ff[cmd.ch]) + prod_ff;
   assign level_sat = (level_sum > sles_pkg::LEVEL_MAX) ? 26'sd33554431 :
                      (level_sum < sles_pkg::LEVEL_MIN) ? -26'sd33554432 :
                      level_sum[25:0];
   assign phase_inc = phase_ff + 7'd1;
   assign alpha_ch  = to_channel(level_ff[0]);

   assign err_restart = (blinks_left_ff == 8'd0) && (pause_left_ff == 8'd0);
   assign err_pause   = (blinks_left_ff == 8'd0) && (pause_left_ff != 8'd0);
   assign blink_dark  = (phase_inc < BLINK_HALF);
   assign blink_lit   = !blink_dark && (phase_inc < BLINK_FULL);

   always_comb begin
      status.flow_run = (mode_ff == sles_pkg::MODE_FLOW) && (seg_time_ff < SEG_LIMIT);
      status.err_emit = (mode_ff == sles_pkg::MODE_ERROR) && !err_restart &&
                        (err_pause || blink_dark || blink_lit);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sles_pkg::MODE_IDLE;
         blinks_cfg_ff <= 8'd0;
      end else if (csr_write) begin
         case (csr_index)
            sles_pkg::CSR_EFFECT_MODE:  mode_ff       <= sles_pkg::mode_type'(csr_wdata[1:0]);
            sles_pkg::CSR_ERROR_BLINKS: blinks_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow state
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff      <= 3'd0;
         seg_time_ff <= 16'd0;
         for (int k = 0; k < 4; k++) begin
            level_ff[k] <= seg_level(3'd0, 2'(k));
            step_ff[k]  <= seg_step(3'd0, 2'(k));
         end
      end else begin
         if (cmd.accept && (mode_ff == sles_pkg::MODE_FLOW)) begin
            if (seg_time_ff < SEG_LIMIT) begin
               seg_time_ff <= time_sum[16] ? 16'hFFFF : time_sum[15:0];
            end else begin
               seg_time_ff <= 16'd0;
               seg_ff      <= seg_next;
               for (int k = 0; k < 4; k++) begin
                  level_ff[k] <= seg_level(seg_next, 2'(k));
                  step_ff[k]  <= seg_step(seg_next, 2'(k));
               end
            end
         end
         if (cmd.acc) begin
            level_ff[cmd.ch] <= level_sat;
         end
      end
   end

   // error blink state
   always_ff @(posedge clock) begin
      if (reset) begin
         blinks_left_ff <= 8'd0;
         pause_left_ff  <= sles_pkg::PAUSE_RESET;
         phase_ff       <= 7'd0;
      end else if (cmd.accept && (mode_ff == sles_pkg::MODE_ERROR)) begin
         if (err_restart) begin
            blinks_left_ff <= blinks_cfg_ff;
            pause_left_ff  <= PAUSE_INIT;
         end else if (err_pause) begin
            pause_left_ff <= pause_left_ff - 8'd1;
         end else if (blink_dark || blink_lit) begin
            phase_ff <= phase_inc;
         end else begin
            phase_ff       <= 7'd0;
            blinks_left_ff <= blinks_left_ff - 8'd1;
         end
      end
   end

   // arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         d_ff <= req_elapsed_ms;
         // error results go straight into the scale products
         prod_rgb_ff[0] <= (!err_pause && blink_lit) ? DIM_PROD : 16'd0;
         prod_rgb_ff[1] <= 16'd0;
         prod_rgb_ff[2] <= 16'd0;
      end
      if (cmd.mul) begin
         prod_ff <= step_ff[cmd.ch] * $signed({1'b0, d_ff});
      end
      if (cmd.scale) begin
         for (int k = 0; k < 3; k++) begin
            prod_rgb_ff[k] <= 16'(to_channel(level_ff[k + 1])) * 16'(alpha_ch);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_red_ff   <= div255(prod_rgb_ff[0]);
         rsp_green_ff <= div255(prod_rgb_ff[1]);
         rsp_blue_ff  <= div255(prod_rgb_ff[2]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

`default_nettype wire

[hdl/status_led_effect_sequencer.sv]
// status led effect sequencer: one tick in, at most one rgb beat out
// top level joining sles_ctrl and sles_dp; uses sles_pkg
//
// req channel: one beat per loop tick with the milliseconds since the last tick.
// rsp channel: red, green and blue levels, alpha scaled, only on ticks that update the led.
// csr port: csr_write with csr_index 0 sets the effect mode (0 idle, 1 color flow,
//   2 error blink), index 1 sets the blink count; write only while no tick is in flight.
// a flow tick steps through the controller states: the one shared 26x11 multiplier
//   runs a multiply and an accumulate state for each of alpha, red, green and blue,
//   then one state scales the channels by alpha and one loads the result register,
//   which raises rsp_valid; the next tick is accepted once the controller is idle again.
// an error tick goes from accept straight to the result load and raises rsp_valid;
//   a tick that gives no beat leaves the controller idle.
// req_stall is high from accept until the result is in the result register.
// while rsp_stall holds a beat, the next tick is accepted and runs up to its
//   result load, then waits for the result register to free.
// reset (synchronous) clears rsp_valid, loads the first fade segment,
//   sets idle mode and zero blinks; no clearing pass is needed.
`default_nettype none

module status_led_effect_sequencer #(
   parameter int SEGMENT_MS  = 500,
   parameter int PAUSE_TICKS = 200,
   parameter int BLINK_TICKS = 100
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [9:0] req_elapsed_ms,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   sles_pkg::dp_cmd_type    cmd;
   sles_pkg::dp_status_type status;

   sles_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sles_dp #(
      .SEGMENT_MS  (SEGMENT_MS),
      .PAUSE_TICKS (PAUSE_TICKS),
      .BLINK_TICKS (BLINK_TICKS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_elapsed_ms (req_elapsed_ms),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

endmodule

`default_nettype wire
